### sv/id_allocator_with_recycling_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the identifier allocator
// Shared wrappers around concurrent assertions clocked on clock, reset-gated.
// ----------------------------------------------------------------------------
`ifndef ID_ALLOCATOR_WITH_RECYCLING_TOP_MACROS_SVH
`define ID_ALLOCATOR_WITH_RECYCLING_TOP_MACROS_SVH

// Same-cycle implication.
`define IDA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define IDA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/ida_pkg.sv
// ----------------------------------------------------------------------------
// Identifier allocator package
// Widths, depths, codes and shared structs of the identifier allocator.
// ----------------------------------------------------------------------------
package ida_pkg;

   localparam int ID_WIDTH        = 16;
   localparam int FREE_DEPTH      = 1024;
   localparam int ADDR_WIDTH      = $clog2(FREE_DEPTH);
   localparam int COUNT_WIDTH     = $clog2(FREE_DEPTH + 1);
   localparam int OUT_DEPTH       = 3;
   localparam int OUT_PTR_WIDTH   = $clog2(OUT_DEPTH);
   localparam int OUT_COUNT_WIDTH = $clog2(OUT_DEPTH + 1);

   typedef enum logic {
      ACT_ALLOC   = 1'b0,
      ACT_RELEASE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_POOL_FULL = 2'd2
   } status_type;

   // Free stack access command.
   typedef struct packed {
      logic                  we;
      logic [ADDR_WIDTH-1:0] waddr;
      logic [ID_WIDTH-1:0]   wdata;
      logic                  re;
      logic [ADDR_WIDTH-1:0] raddr;
   } mem_cmd_type;

   // One finished result leaving the decision stage.
   typedef struct packed {
      logic                valid;
      logic [ID_WIDTH-1:0] id;
      status_type          status;
   } res_type;

   // One buffered result word.
   typedef struct packed {
      logic [ID_WIDTH-1:0] id;
      status_type          status;
   } rsp_type;

endpackage

### sv/ida_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ida_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/ida_core.sv
// ----------------------------------------------------------------------------
// Identifier allocator decision stage
// Holds the counter, exhausted flag, stack count and mode; decides each word
// in the accept cycle and registers the result.
// ----------------------------------------------------------------------------
module ida_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_wr_data,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic                                 action,
   input  logic [ida_pkg::ID_WIDTH-1:0]         release_id,
   input  logic [ida_pkg::ID_WIDTH-1:0]         ram_rdata,
   input  logic [ida_pkg::OUT_COUNT_WIDTH-1:0]  out_count,
   output ida_pkg::mem_cmd_type                 mem_cmd,
   output ida_pkg::res_type                     res
);
   import ida_pkg::*;

   logic                   mode_ff;
   logic [ID_WIDTH-1:0]    counter_ff, counter_in;
   logic                   exh_ff, exh_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   s1_valid_ff;
   logic                   s1_pop_ff, s1_pop_in;
   logic [ID_WIDTH-1:0]    s1_id_ff, s1_id_in;
   status_type             s1_status_ff, s1_status_in;

   logic                   fire;
   logic [ID_WIDTH-1:0]    counter_inc;
   logic [COUNT_WIDTH-1:0] count_dec;
   logic [OUT_COUNT_WIDTH:0] credit;

   // Accept only while the output buffer has room for every result in flight.
   assign credit     = {1'b0, out_count} + {{OUT_COUNT_WIDTH{1'b0}}, s1_valid_ff};
   assign req_tready = credit < (OUT_COUNT_WIDTH + 1)'(OUT_DEPTH);
   assign fire       = req_tvalid && req_tready;

   assign counter_inc = counter_ff + 1'b1;
   assign count_dec   = count_ff - 1'b1;

   // Decide the word from the current state.
   always_comb begin
      counter_in    = counter_ff;
      exh_in        = exh_ff;
      count_in      = count_ff;
      s1_pop_in     = 1'b0;
      s1_id_in      = '0;
      s1_status_in  = STATUS_OK;
      mem_cmd.we    = 1'b0;
      mem_cmd.waddr = count_ff[ADDR_WIDTH-1:0];
      mem_cmd.wdata = release_id;
      mem_cmd.re    = 1'b0;
      mem_cmd.raddr = count_dec[ADDR_WIDTH-1:0];
      if (fire) begin
         if (!mode_ff) begin
            // Monotonic mode: a release is dropped.
            if (action == ACT_ALLOC) begin
               if (exh_ff) begin
                  s1_status_in = STATUS_EXHAUSTED;
               end else begin
                  counter_in = counter_inc;
                  if (counter_inc == '0) begin
                     exh_in       = 1'b1;
                     s1_status_in = STATUS_EXHAUSTED;
                  end else begin
                     s1_id_in = counter_inc;
                  end
               end
            end
         end else if (action == ACT_ALLOC) begin
            // Recycling allocate: pop the newest freed ID, else bump the counter.
            if (count_ff != '0) begin
               count_in   = count_dec;
               mem_cmd.re = 1'b1;
               s1_pop_in  = 1'b1;
            end else begin
               counter_in = counter_inc;
               if (counter_inc == '0) begin
                  s1_status_in = STATUS_EXHAUSTED;
               end else begin
                  s1_id_in = counter_inc;
               end
            end
         end else begin
            // Recycling release: push unless the stack is full.
            if (count_ff == COUNT_WIDTH'(FREE_DEPTH)) begin
               s1_status_in = STATUS_POOL_FULL;
            end else begin
               mem_cmd.we = 1'b1;
               count_in   = count_ff + 1'b1;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         counter_ff  <= '0;
         exh_ff      <= 1'b0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         counter_ff  <= counter_in;
         exh_ff      <= exh_in;
         count_ff    <= count_in;
         s1_valid_ff <= fire;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (fire) begin
         s1_pop_ff    <= s1_pop_in;
         s1_id_ff     <= s1_id_in;
         s1_status_ff <= s1_status_in;
      end
   end

   // A popped ID comes from the stack memory's registered read data in the cycle after the read.
   assign res.valid  = s1_valid_ff;
   assign res.id     = s1_pop_ff ? ram_rdata : s1_id_ff;
   assign res.status = s1_status_ff;

endmodule

### sv/ida_out_buf.sv
// ----------------------------------------------------------------------------
// Identifier allocator output buffer
// Small register queue that decouples the result side from the decision stage.
// ----------------------------------------------------------------------------
module ida_out_buf (
   input  logic                                clock,
   input  logic                                reset,
   input  ida_pkg::res_type                    res,
   output logic [ida_pkg::OUT_COUNT_WIDTH-1:0] out_count,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output ida_pkg::rsp_type                    rsp
);
   import ida_pkg::*;

   rsp_type                    entry_ff [OUT_DEPTH];
   logic [OUT_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OUT_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                       push, pop;

   assign push = res.valid;
   assign pop  = rsp_tvalid && rsp_tready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == OUT_PTR_WIDTH'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == OUT_PTR_WIDTH'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{id: res.id, status: res.status};
      end
   end

   assign out_count  = count_ff;
   assign rsp_tvalid = count_ff != '0;
   assign rsp        = entry_ff[rd_ptr_ff];

endmodule

### sv/id_allocator_with_recycling_top.sv
// A result word passes through the result register and then the output queue.
// Throughput: one request word per cycle; the three-entry output queue keeps
// requests flowing while a result waits, and stops them once the queue and the
// result register together hold three words.
// Reset clears the mode, counter, exhausted flag, stack count and queues.
// Free stack memory contents are not cleared; only pushed entries are read.
// ----------------------------------------------------------------------------
// Identifier allocator with recycling
// Allocates IDs from a wrapping counter, optionally reusing released IDs
// from a LIFO free stack held in a block memory.
// ----------------------------------------------------------------------------
module id_allocator_with_recycling_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,   // recycling_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [15:0] release_id
   input  logic [0:0]  req_tuser,     // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [15:0] id
   output logic [1:0]  rsp_tuser      // [1:0] status
);
   import ida_pkg::*;

   `include "id_allocator_with_recycling_top_macros.svh"

   mem_cmd_type                mem_cmd;
   res_type                    res;
   rsp_type                    rsp;
   logic [ID_WIDTH-1:0]        ram_rdata;
   logic [OUT_COUNT_WIDTH-1:0] out_count;

   // Decision stage with all allocator state.
   ida_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .action      (req_tuser[0]),
      .release_id  (req_tdata[ID_WIDTH-1:0]),
      .ram_rdata   (ram_rdata),
      .out_count   (out_count),
      .mem_cmd     (mem_cmd),
      .res         (res)
   );

   // Free stack storage.
   ida_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (FREE_DEPTH)
   ) u_free_stack (
      .clock (clock),
      .we    (mem_cmd.we),
      .waddr (mem_cmd.waddr),
      .wdata (mem_cmd.wdata),
      .re    (mem_cmd.re),
      .raddr (mem_cmd.raddr),
      .rdata (ram_rdata)
   );

   // Result queue.
   ida_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .res        (res),
      .out_count  (out_count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = rsp.id;
   assign rsp_tuser = rsp.status;

   // Every accepted word yields a result from the decision stage next cycle.
   `IDA_ASSERT_NEXT(a_accept_gives_result, req_tvalid && req_tready, res.valid,
                    "accepted word produced no result")
   // The queue always has room when a result arrives.
   `IDA_ASSERT_NOW(a_queue_room, res.valid, out_count < OUT_COUNT_WIDTH'(OUT_DEPTH),
                   "result queue overflow")
   // A failed result never carries an ID.
   `IDA_ASSERT_NOW(a_fail_zero_id, res.valid && res.status != STATUS_OK, res.id == '0,
                   "nonzero id on failed result")

endmodule
